// ===== rtl/core/hcsc_pkg.sv =====
// Shared types, constants and helper functions of the constant segment compressor.
package hcsc_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int LEN_W          = 12;
    localparam int WLEN_W         = 5;
    localparam int NWIN_W         = 8;
    localparam int EBND_W         = 15;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 15;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BOUND  = 2'd2;

    localparam logic [WLEN_W-1:0] WLEN_RST = 5'd8;
    localparam logic [NWIN_W-1:0] NWIN_RST = 8'd4;
    localparam logic [EBND_W-1:0] EBND_RST = 15'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EOS,
        ST_RD,
        ST_EV,
        ST_END
    } ctrl_state_t;

    typedef struct packed {
        logic [LEN_W-1:0]           len;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } seg_t;

    // floor((lo + hi) / 2)
    function automatic logic signed [SAMPLE_W-1:0] seg_mid(
        input logic signed [SAMPLE_W-1:0] lo,
        input logic signed [SAMPLE_W-1:0] hi
    );
        logic signed [SAMPLE_W:0] s;
        s = (SAMPLE_W+1)'(lo) + (SAMPLE_W+1)'(hi);
        return s[SAMPLE_W:1];
    endfunction

    function automatic logic signed [SAMPLE_W:0] seg_span(
        input logic signed [SAMPLE_W-1:0] lo,
        input logic signed [SAMPLE_W-1:0] hi
    );
        return (SAMPLE_W+1)'(hi) - (SAMPLE_W+1)'(lo);
    endfunction

endpackage

// ===== rtl/core/hcsc_store.sv =====
// Window sample memory: one write port, one registered read port.
module hcsc_store #(
    parameter int MAX_WINDOW = hcsc_pkg::MAX_WINDOW_DEF,
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [IDX_W-1:0]                     wr_addr,
    input  logic signed [hcsc_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                                 rd_en,
    input  logic [IDX_W-1:0]                     rd_addr,
    output logic signed [hcsc_pkg::SAMPLE_W-1:0] rd_data
);

    logic signed [hcsc_pkg::SAMPLE_W-1:0] mem [MAX_WINDOW];
    logic signed [hcsc_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hcsc_out.sv =====
// Result output register with valid/stall handshake.
module hcsc_out (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 emit_valid,
    input  hcsc_pkg::seg_t                       emit_seg,
    output logic                                 out_free,
    output logic                                 seg_valid,
    input  logic                                 seg_stall,
    output logic [hcsc_pkg::LEN_W-1:0]           seg_length,
    output logic signed [hcsc_pkg::SAMPLE_W-1:0] seg_value,
    output logic                                 run_last
);

    logic           valid_reg;
    logic           valid_next;
    hcsc_pkg::seg_t seg_reg;

    assign out_free = !valid_reg || !seg_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit_valid)
        begin
            valid_next = 1'b1;
        end
        else if (!seg_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load only when the slot is empty or being drained
    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            seg_reg <= emit_seg;
        end
    end

    assign seg_valid  = valid_reg;
    assign seg_length = seg_reg.len;
    assign seg_value  = seg_reg.value;
    assign run_last   = seg_reg.last;

endmodule

// ===== rtl/core/hcsc_ctrl.sv =====
// Sequencer: window and buffer tracking, buffer merge decision and window replay.
module hcsc_ctrl #(
    parameter int MAX_WINDOW = hcsc_pkg::MAX_WINDOW_DEF,
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int FILL_W = $clog2(MAX_WINDOW + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [hcsc_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   end_of_stream,
    input  logic                                   cfg_wr_en,
    input  logic [hcsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hcsc_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   wr_en,
    output logic [IDX_W-1:0]                       wr_addr,
    output logic signed [hcsc_pkg::SAMPLE_W-1:0]   wr_data,
    output logic                                   rd_en,
    output logic [IDX_W-1:0]                       rd_addr,
    input  logic signed [hcsc_pkg::SAMPLE_W-1:0]   rd_data,
    input  logic                                   out_free,
    output logic                                   emit_valid,
    output hcsc_pkg::seg_t                         emit_seg
);

    localparam int SW     = hcsc_pkg::SAMPLE_W;
    localparam int NW     = hcsc_pkg::NWIN_W;
    localparam int PROD_W = NW + FILL_W;

    hcsc_pkg::ctrl_state_t state_reg, state_next;

    logic [hcsc_pkg::WLEN_W-1:0] wlen_reg;
    logic [NW-1:0]               nwin_reg;
    logic [hcsc_pkg::EBND_W-1:0] ebnd_reg;

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [NW-1:0]      bw_reg, bw_next;
    logic               eos_reg, eos_next;
    logic [FILL_W-1:0]  rp_idx_reg, rp_idx_next;
    logic [FILL_W-1:0]  rp_len_reg, rp_len_next;

    logic signed [SW-1:0] wmin_reg, wmin_next;
    logic signed [SW-1:0] wmax_reg, wmax_next;
    logic signed [SW-1:0] bmin_reg, bmin_next;
    logic signed [SW-1:0] bmax_reg, bmax_next;
    logic signed [SW-1:0] rp_lo_reg, rp_lo_next;
    logic signed [SW-1:0] rp_hi_reg, rp_hi_next;

    logic [FILL_W-1:0]    eff_wlen;
    logic [NW-1:0]        eff_nwin;
    logic signed [SW:0]   lim;
    logic                 win_full;
    logic signed [SW-1:0] nlo, nhi;
    logic                 fits;
    logic                 win_wide;
    logic [NW-1:0]        bw_inc;
    logic                 buf_full;
    logic [NW-1:0]        mul_a;
    logic [PROD_W-1:0]    prod;
    logic [hcsc_pkg::LEN_W-1:0] buf_len;
    logic signed [SW-1:0] ulo, uhi;
    logic                 brk;

    // effective configuration
    always_comb
    begin
        if (wlen_reg < 5'd2)
        begin
            eff_wlen = FILL_W'(2);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            eff_wlen = FILL_W'(MAX_WINDOW);
        end
        else
        begin
            eff_wlen = FILL_W'(wlen_reg);
        end
        eff_nwin = (nwin_reg < 8'd2) ? 8'd2 : nwin_reg;
        lim      = (SW+1)'({ebnd_reg, 1'b0});
    end

    // merge decision terms
    always_comb
    begin
        win_full = fill_reg >= eff_wlen;
        nlo      = wmin_reg;
        nhi      = wmax_reg;
        if (bw_reg != '0)
        begin
            if (bmin_reg < wmin_reg)
            begin
                nlo = bmin_reg;
            end
            if (bmax_reg > wmax_reg)
            begin
                nhi = bmax_reg;
            end
        end
        fits     = hcsc_pkg::seg_span(nlo, nhi) <= lim;
        win_wide = hcsc_pkg::seg_span(wmin_reg, wmax_reg) > lim;
        bw_inc   = bw_reg + 8'd1;
        buf_full = bw_inc >= eff_nwin;
        mul_a    = (state_reg == hcsc_pkg::ST_CHECK && fits) ? bw_inc : bw_reg;
        prod     = PROD_W'(mul_a) * PROD_W'(eff_wlen);
        buf_len  = hcsc_pkg::LEN_W'(prod);
    end

    // replay step terms
    always_comb
    begin
        ulo = (rd_data < rp_lo_reg) ? rd_data : rp_lo_reg;
        uhi = (rd_data > rp_hi_reg) ? rd_data : rp_hi_reg;
        brk = (rp_len_reg != '0) && (hcsc_pkg::seg_span(ulo, uhi) > lim);
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bw_next     = bw_reg;
        eos_next    = eos_reg;
        rp_idx_next = rp_idx_reg;
        rp_len_next = rp_len_reg;
        wmin_next   = wmin_reg;
        wmax_next   = wmax_reg;
        bmin_next   = bmin_reg;
        bmax_next   = bmax_reg;
        rp_lo_next  = rp_lo_reg;
        rp_hi_next  = rp_hi_reg;

        item_stall  = (state_reg != hcsc_pkg::ST_IDLE);
        wr_en       = 1'b0;
        wr_addr     = fill_reg[IDX_W-1:0];
        wr_data     = sample;
        rd_en       = 1'b0;
        rd_addr     = rp_idx_reg[IDX_W-1:0];
        emit_valid  = 1'b0;
        emit_seg.len   = buf_len;
        emit_seg.value = hcsc_pkg::seg_mid(bmin_reg, bmax_reg);
        emit_seg.last  = 1'b0;

        unique case (state_reg)
            hcsc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (fill_reg < FILL_W'(MAX_WINDOW))
                    begin
                        wr_en = 1'b1;
                        if (fill_reg == '0)
                        begin
                            wmin_next = sample;
                            wmax_next = sample;
                        end
                        else
                        begin
                            if (sample < wmin_reg)
                            begin
                                wmin_next = sample;
                            end
                            if (sample > wmax_reg)
                            begin
                                wmax_next = sample;
                            end
                        end
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    eos_next   = end_of_stream;
                    state_next = hcsc_pkg::ST_CHECK;
                end
            end

            hcsc_pkg::ST_CHECK:
            begin
                if (!win_full)
                begin
                    state_next = eos_reg ? hcsc_pkg::ST_EOS : hcsc_pkg::ST_IDLE;
                end
                else if (fits)
                begin
                    if (buf_full)
                    begin
                        // merged buffer goes out once the output slot is free; nothing can follow it
                        if (out_free)
                        begin
                            emit_valid     = 1'b1;
                            emit_seg.value = hcsc_pkg::seg_mid(nlo, nhi);
                            emit_seg.last  = 1'b1;
                            bw_next        = '0;
                            fill_next      = '0;
                            state_next     = hcsc_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        bmin_next  = nlo;
                        bmax_next  = nhi;
                        bw_next    = bw_inc;
                        fill_next  = '0;
                        state_next = eos_reg ? hcsc_pkg::ST_EOS : hcsc_pkg::ST_IDLE;
                    end
                end
                else if (bw_reg == '0 || out_free)
                begin
                    if (bw_reg != '0)
                    begin
                        emit_valid    = 1'b1;
                        emit_seg.last = !win_wide && !eos_reg;
                    end
                    if (win_wide)
                    begin
                        bw_next     = '0;
                        rp_idx_next = '0;
                        rp_len_next = '0;
                        state_next  = hcsc_pkg::ST_RD;
                    end
                    else
                    begin
                        bmin_next  = wmin_reg;
                        bmax_next  = wmax_reg;
                        bw_next    = 8'd1;
                        fill_next  = '0;
                        state_next = eos_reg ? hcsc_pkg::ST_EOS : hcsc_pkg::ST_IDLE;
                    end
                end
            end

            hcsc_pkg::ST_EOS:
            begin
                if (bw_reg == '0 || out_free)
                begin
                    if (bw_reg != '0)
                    begin
                        emit_valid    = 1'b1;
                        emit_seg.last = (fill_reg == '0);
                    end
                    bw_next     = '0;
                    rp_idx_next = '0;
                    rp_len_next = '0;
                    state_next  = (fill_reg != '0) ? hcsc_pkg::ST_RD : hcsc_pkg::ST_IDLE;
                end
            end

            hcsc_pkg::ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = hcsc_pkg::ST_EV;
            end

            hcsc_pkg::ST_EV:
            begin
                // hold on a break until the output slot frees
                if (!brk || out_free)
                begin
                    if (brk)
                    begin
                        emit_valid     = 1'b1;
                        emit_seg.len   = hcsc_pkg::LEN_W'(rp_len_reg);
                        emit_seg.value = hcsc_pkg::seg_mid(rp_lo_reg, rp_hi_reg);
                        rp_lo_next     = rd_data;
                        rp_hi_next     = rd_data;
                        rp_len_next    = FILL_W'(1);
                    end
                    else if (rp_len_reg == '0)
                    begin
                        rp_lo_next  = rd_data;
                        rp_hi_next  = rd_data;
                        rp_len_next = FILL_W'(1);
                    end
                    else
                    begin
                        rp_lo_next  = ulo;
                        rp_hi_next  = uhi;
                        rp_len_next = rp_len_reg + FILL_W'(1);
                    end
                    rp_idx_next = rp_idx_reg + FILL_W'(1);
                    state_next  = (rp_idx_reg + FILL_W'(1) == fill_reg) ?
                                  hcsc_pkg::ST_END : hcsc_pkg::ST_RD;
                end
            end

            hcsc_pkg::ST_END:
            begin
                if (out_free)
                begin
                    emit_valid     = 1'b1;
                    emit_seg.len   = hcsc_pkg::LEN_W'(rp_len_reg);
                    emit_seg.value = hcsc_pkg::seg_mid(rp_lo_reg, rp_hi_reg);
                    emit_seg.last  = 1'b1;
                    fill_next      = '0;
                    state_next     = hcsc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hcsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcsc_pkg::ST_IDLE;
            fill_reg  <= '0;
            bw_reg    <= '0;
            eos_reg   <= 1'b0;
            wlen_reg  <= hcsc_pkg::WLEN_RST;
            nwin_reg  <= hcsc_pkg::NWIN_RST;
            ebnd_reg  <= hcsc_pkg::EBND_RST;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bw_reg    <= bw_next;
            eos_reg   <= eos_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    hcsc_pkg::CFG_WINDOW_LEN:
                    begin
                        wlen_reg <= cfg_data[hcsc_pkg::WLEN_W-1:0];
                    end
                    hcsc_pkg::CFG_WINDOWS_PER:
                    begin
                        nwin_reg <= cfg_data[NW-1:0];
                    end
                    hcsc_pkg::CFG_ERROR_BOUND:
                    begin
                        ebnd_reg <= cfg_data[hcsc_pkg::EBND_W-1:0];
                    end
                    default:
                    begin
                        // drop writes to unknown indexes
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rp_idx_reg <= rp_idx_next;
        rp_len_reg <= rp_len_next;
        wmin_reg   <= wmin_next;
        wmax_reg   <= wmax_next;
        bmin_reg   <= bmin_next;
        bmax_reg   <= bmax_next;
        rp_lo_reg  <= rp_lo_next;
        rp_hi_reg  <= rp_hi_next;
    end

endmodule

// ===== rtl/core/hybrid_constant_segment_compressor.sv =====
// Hybrid piecewise-constant compressor: window store, sequencer and output register.
//
// Input channel: item_valid / item_stall carry one signed 16-bit sample and an
// end_of_stream flag per request. Output channel: seg_valid / seg_stall carry
// one constant segment per request (seg_length, seg_value, run_last); run_last
// marks the final segment caused by one input sample. A sample may cause none.
// Configuration: cfg_wr_en with cfg_index 0 (window_len), 1 (windows_per_buffer)
// or 2 (error_bound) and cfg_data; write only while idle.
// Sequencing: a sample is accepted, then the window/buffer decision is made;
// the decision may emit a buffer segment, and an end of stream adds a
// buffer flush state. A window replay reads the sample memory through
// its single registered read port, a read and an evaluate state per stored
// sample, then an end state emits the final segment. item_stall is high outside idle.
// Segments leave through one output register; while seg_stall is high the
// sequencer holds at the next segment and item_stall stays high.
// Reset (rst_n low, asynchronous) empties window and buffer and restores
// window_len 8, windows_per_buffer 4, error_bound 16; no clearing pass is run.
module hybrid_constant_segment_compressor #(
    parameter int MAX_WINDOW = hcsc_pkg::MAX_WINDOW_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [hcsc_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   end_of_stream,
    output logic                                   seg_valid,
    input  logic                                   seg_stall,
    output logic [hcsc_pkg::LEN_W-1:0]             seg_length,
    output logic signed [hcsc_pkg::SAMPLE_W-1:0]   seg_value,
    output logic                                   run_last,
    input  logic                                   cfg_wr_en,
    input  logic [hcsc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hcsc_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic                                 wr_en;
    logic [IDX_W-1:0]                     wr_addr;
    logic signed [hcsc_pkg::SAMPLE_W-1:0] wr_data;
    logic                                 rd_en;
    logic [IDX_W-1:0]                     rd_addr;
    logic signed [hcsc_pkg::SAMPLE_W-1:0] rd_data;
    logic                                 out_free;
    logic                                 emit_valid;
    hcsc_pkg::seg_t                       emit_seg;

    hcsc_store #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hcsc_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_free      (out_free),
        .emit_valid    (emit_valid),
        .emit_seg      (emit_seg)
    );

    hcsc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit_seg   (emit_seg),
        .out_free   (out_free),
        .seg_valid  (seg_valid),
        .seg_stall  (seg_stall),
        .seg_length (seg_length),
        .seg_value  (seg_value),
        .run_last   (run_last)
    );

endmodule

// ===== verif/hybrid_constant_segment_compressor_tb.sv =====
// Self-checking testbench for the hybrid constant segment compressor.
`timescale 1ns / 100ps

module hybrid_constant_segment_compressor_tb;

    localparam int IDLE_GAP       = 40;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 1500;

    typedef struct {
        logic signed [hcsc_pkg::SAMPLE_W-1:0] value;
        logic                                 eos;
    } sample_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                                 item_valid    = 1'b0;
    logic                                 item_stall;
    logic signed [hcsc_pkg::SAMPLE_W-1:0] sample        = '0;
    logic                                 end_of_stream = 1'b0;
    logic                                 seg_valid;
    logic                                 seg_stall     = 1'b0;
    logic [hcsc_pkg::LEN_W-1:0]           seg_length;
    logic signed [hcsc_pkg::SAMPLE_W-1:0] seg_value;
    logic                                 run_last;
    logic                                 cfg_wr_en     = 1'b0;
    logic [hcsc_pkg::CFG_IDX_W-1:0]       cfg_index     = hcsc_pkg::CFG_WINDOW_LEN;
    logic [hcsc_pkg::CFG_DATA_W-1:0]      cfg_data      = '0;

    hybrid_constant_segment_compressor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .sample        (sample),
        .end_of_stream (end_of_stream),
        .seg_valid     (seg_valid),
        .seg_stall     (seg_stall),
        .seg_length    (seg_length),
        .seg_value     (seg_value),
        .run_last      (run_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Shadow of the compressor: configuration, window and buffer.
    logic [hcsc_pkg::WLEN_W-1:0] reg_wlen  = hcsc_pkg::WLEN_RST;
    logic [hcsc_pkg::NWIN_W-1:0] reg_nwin  = hcsc_pkg::NWIN_RST;
    logic [hcsc_pkg::EBND_W-1:0] reg_bound = hcsc_pkg::EBND_RST;

    int win_samples [hcsc_pkg::MAX_WINDOW_DEF];
    int win_fill  = 0;
    int win_lo    = 0;
    int win_hi    = 0;
    int buf_count = 0;
    int buf_lo    = 0;
    int buf_hi    = 0;

    hcsc_pkg::seg_t segs_due [$];
    sample_req_t    pending  [$];

    int fail_count    = 0;
    int items_taken   = 0;
    int segs_seen     = 0;
    int settings_used = 0;
    int step_segs;

    int   burst_left     = 0;
    int   gap_left       = 0;
    int   hold_left      = 0;
    int   stall_mode     = 0;
    int   mode_left      = 0;
    int   idle_cycles    = 0;
    logic long_hold_done = 1'b0;

    function automatic int window_size();
        if (reg_wlen < 2)
            return 2;
        if (reg_wlen > hcsc_pkg::MAX_WINDOW_DEF)
            return hcsc_pkg::MAX_WINDOW_DEF;
        return int'(reg_wlen);
    endfunction

    function automatic int floor_midpoint(input int lo, input int hi);
        return (lo + hi) >>> 1;
    endfunction

    task automatic push_segment(input int len, input int val);
        hcsc_pkg::seg_t s;
        s.len   = len[hcsc_pkg::LEN_W-1:0];
        s.value = val[hcsc_pkg::SAMPLE_W-1:0];
        s.last  = 1'b0;
        segs_due.insert(segs_due.size(), s);
        step_segs++;
    endtask

    task automatic flush_buffer();
        if (buf_count > 0) begin
            push_segment(buf_count * window_size(), floor_midpoint(buf_lo, buf_hi));
            buf_count = 0;
        end
    endtask

    // Greedy split of the stored window into constant runs.
    task automatic replay_window(input int n);
        int lo;
        int hi;
        int val;
        int len;
        int v;
        lo  = 0;
        hi  = 0;
        val = 0;
        len = 0;
        for (int i = 0; i < n && i < hcsc_pkg::MAX_WINDOW_DEF; i++) begin
            v = win_samples[i];
            if (len == 0) begin
                lo = v;
                hi = v;
            end
            else begin
                if (v < lo)
                    lo = v;
                if (v > hi)
                    hi = v;
                if (hi - lo > 2 * int'(reg_bound)) begin
                    push_segment(len, val);
                    lo  = v;
                    hi  = v;
                    len = 0;
                end
            end
            val = floor_midpoint(lo, hi);
            len++;
        end
        if (len > 0)
            push_segment(len, val);
    endtask

    task automatic predict_segments(input logic signed [hcsc_pkg::SAMPLE_W-1:0] value,
                                    input logic eos);
        int v;
        int lim;
        int nlo;
        int nhi;
        int nwin;
        v         = int'(value);
        lim       = 2 * int'(reg_bound);
        nwin      = (reg_nwin < 2) ? 2 : int'(reg_nwin);
        step_segs = 0;
        if (win_fill < hcsc_pkg::MAX_WINDOW_DEF) begin
            win_samples[win_fill] = v;
            if (win_fill == 0) begin
                win_lo = v;
                win_hi = v;
            end
            else begin
                if (v < win_lo)
                    win_lo = v;
                if (v > win_hi)
                    win_hi = v;
            end
            win_fill++;
        end
        if (win_fill >= window_size()) begin
            nlo = win_lo;
            nhi = win_hi;
            if (buf_count > 0) begin
                if (buf_lo < nlo)
                    nlo = buf_lo;
                if (buf_hi > nhi)
                    nhi = buf_hi;
            end
            if (nhi - nlo <= lim) begin
                buf_lo = nlo;
                buf_hi = nhi;
                buf_count++;
                if (buf_count >= nwin)
                    flush_buffer();
            end
            else begin
                flush_buffer();
                if (win_hi - win_lo > lim)
                    replay_window(win_fill);
                else begin
                    buf_lo    = win_lo;
                    buf_hi    = win_hi;
                    buf_count = 1;
                end
            end
            win_fill = 0;
        end
        if (eos) begin
            flush_buffer();
            if (win_fill > 0)
                replay_window(win_fill);
            win_fill = 0;
        end
        if (step_segs > 0)
            segs_due[segs_due.size() - 1].last = 1'b1;
    endtask

    task automatic add_sample(input int v, input logic eos);
        sample_req_t r;
        r.value = v[hcsc_pkg::SAMPLE_W-1:0];
        r.eos   = eos;
        pending.insert(pending.size(), r);
    endtask

    // Writes all three registers; the block must be idle.
    task automatic set_config(input int wl, input int nw, input int eb);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= hcsc_pkg::CFG_WINDOW_LEN;
        cfg_data  <= wl[hcsc_pkg::CFG_DATA_W-1:0];
        reg_wlen   = wl[hcsc_pkg::WLEN_W-1:0];
        @(posedge clk);
        cfg_index <= hcsc_pkg::CFG_WINDOWS_PER;
        cfg_data  <= nw[hcsc_pkg::CFG_DATA_W-1:0];
        reg_nwin   = nw[hcsc_pkg::NWIN_W-1:0];
        @(posedge clk);
        cfg_index <= hcsc_pkg::CFG_ERROR_BOUND;
        cfg_data  <= eb[hcsc_pkg::CFG_DATA_W-1:0];
        reg_bound  = eb[hcsc_pkg::EBND_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || item_valid)
            @(posedge clk);
        while (segs_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    // Runs of samples around a base value: mostly within the bound so windows merge,
    // some just over it, some wide noise.
    task automatic queue_stream(input int count);
        int n;
        int lim;
        int spread;
        int base;
        int run;
        int v;
        int pick;
        logic eos;
        n   = 0;
        lim = 2 * int'(reg_bound);
        while (n < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                spread = 0;
            else if (pick < 5)
                spread = $urandom_range(0, lim);
            else if (pick < 7)
                spread = lim;
            else if (pick == 7)
                spread = lim + 1;
            else if (pick == 8)
                spread = $urandom_range(0, 65535);
            else
                spread = 65535;
            if (spread > 65535)
                spread = 65535;
            base = int'($urandom_range(0, 65535 - spread)) - 32768;
            run  = $urandom_range(1, 3 * window_size());
            for (int i = 0; i < run && n < count; i++) begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    v = base;
                else if (pick == 1)
                    v = base + spread;
                else
                    v = base + int'($urandom_range(0, spread));
                eos = ($urandom_range(0, 39) == 0)
                      || (i == run - 1 && $urandom_range(0, 5) == 0);
                add_sample(v, eos);
                n++;
            end
        end
    endtask

    // Sender: bursts of requests with random gaps; predict on acceptance.
    always @(posedge clk) begin
        logic took;
        logic offer;
        if (rst_n) begin
            took = item_valid && !item_stall;
            if (took) begin
                predict_segments(pending[0].value, pending[0].eos);
                void'(pending.pop_front());
                items_taken++;
            end
            if (!item_valid || took) begin
                offer = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() > 0) begin
                    offer          = 1'b1;
                    sample        <= pending[0].value;
                    end_of_stream <= pending[0].eos;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
                item_valid <= offer;
            end
        end
    end

    // Receiver: check each segment, then pick the next stall.
    always @(posedge clk) begin
        hcsc_pkg::seg_t due;
        if (rst_n) begin
            if (seg_valid && !seg_stall) begin
                segs_seen++;
                if (segs_due.size() == 0) begin
                    $error("unexpected segment: length %0d value %0d last %0b",
                           seg_length, seg_value, run_last);
                    fail_count++;
                end
                else begin
                    due = segs_due.pop_front();
                    if (seg_length !== due.len) begin
                        $error("seg_length: expected %0d, got %0d", due.len, seg_length);
                        fail_count++;
                    end
                    if (seg_value !== due.value) begin
                        $error("seg_value: expected %0d, got %0d", due.value, seg_value);
                        fail_count++;
                    end
                    if (run_last !== due.last) begin
                        $error("run_last: expected %0b, got %0b", due.last, run_last);
                        fail_count++;
                    end
                end
            end
            // hold off long enough for the block to back up into its input
            if (!long_hold_done && segs_seen >= 40 && pending.size() > 8) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                seg_stall <= 1'b1;
            end
            else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(8, 64);
                end
                else
                    mode_left--;
                if (stall_mode == 0)
                    seg_stall <= 1'b0;
                else if (stall_mode == 1)
                    seg_stall <= ($urandom_range(0, 3) == 0);
                else
                    seg_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (item_valid && !item_stall) || (seg_valid && !seg_stall) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        int plan [6][3];
        plan = '{'{16, 2, 16}, '{1, 0, 0}, '{31, 255, 32767},
                 '{2, 1, 5}, '{5, 3, 100}, '{17, 7, 1000}};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, merge, flush on misfit, replay, end of stream
        set_config(2, 2, 16);
        add_sample(32767, 1'b0);
        add_sample(32767, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(32767, 1'b1);
        add_sample(5, 1'b1);
        add_sample(10, 1'b0);
        add_sample(40, 1'b0);
        add_sample(42, 1'b0);
        add_sample(10, 1'b0);
        add_sample(0, 1'b0);
        add_sample(33, 1'b0);
        add_sample(-3, 1'b0);
        add_sample(-4, 1'b0);
        add_sample(-1, 1'b1);
        wait_idle();

        // shorten the window while it is part full
        set_config(8, 2, 16);
        add_sample(100, 1'b0);
        add_sample(-50, 1'b0);
        add_sample(7, 1'b0);
        add_sample(300, 1'b0);
        add_sample(0, 1'b0);
        wait_idle();
        set_config(3, 2, 16);
        add_sample(20, 1'b0);
        add_sample(21, 1'b0);
        add_sample(22, 1'b1);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            set_config(plan[p][0], plan[p][1], plan[p][2]);
            queue_stream($urandom_range(16, 28));
            wait_idle();
        end
        set_config($urandom_range(0, 32767), $urandom_range(0, 20), $urandom_range(0, 2000));
        queue_stream($urandom_range(16, 28));
        wait_idle();

        $display("Sent %0d samples under %0d register settings, including out-of-range ones.",
                 items_taken, settings_used);
        $display("Checked %0d segments with random stalls and a long output hold-off.",
                 segs_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hcsc_pkg.sv
rtl/core/hcsc_store.sv
rtl/core/hcsc_out.sv
rtl/core/hcsc_ctrl.sv
rtl/core/hybrid_constant_segment_compressor.sv
verif/hybrid_constant_segment_compressor_tb.sv
